// ----- sv/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helpers of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LOW_U  = 8'h75;
    localparam logic [7:0] C_LOW_N  = 8'h6E;
    localparam logic [7:0] C_LOW_R  = 8'h72;
    localparam logic [7:0] C_LOW_T  = 8'h74;
    localparam logic [7:0] C_LOW_B  = 8'h62;
    localparam logic [7:0] C_LOW_F  = 8'h66;

    localparam logic [15:0] C_LIM1   = 16'h0080;
    localparam logic [15:0] C_LIM2   = 16'h0800;
    localparam logic [7:0]  C_LEAD2  = 8'hC0;
    localparam logic [7:0]  C_LEAD3  = 8'hE0;
    localparam logic [7:0]  C_CONT   = 8'h80;
    localparam logic [7:0]  C_CMASK  = 8'h3F;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX0  = 3'd2,
        MODE_HEX1  = 3'd3,
        MODE_HEX2  = 3'd4,
        MODE_HEX3  = 3'd5
    } t_mode;

    // one decoded request: up to three bytes, count zero means end marker
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            fin;
    } t_group;

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            C_LOW_N: r = 8'h0A;
            C_LOW_R: r = 8'h0D;
            C_LOW_T: r = 8'h09;
            C_LOW_B: r = 8'h08;
            C_LOW_F: r = 8'h0C;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] r;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            r = c - 8'h30;
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            r = c - 8'h57;
        end else begin
            r = c - 8'h37;
        end
        return r[3:0];
    endfunction

endpackage

// ----- sv/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: tracks escape state and turns each input byte into a
// group of zero to three output bytes pushed to the queue.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_string_end,
    input  logic              i_q_full,
    output logic              o_push,
    output jsu_pkg::t_group   o_group
);

    jsu_pkg::t_mode  r_mode;
    jsu_pkg::t_mode  n_mode;
    logic [2:0][7:0] r_hold;
    logic            w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // next state
    always_comb begin
        case (r_mode)
            jsu_pkg::MODE_ESC: begin
                n_mode = (i_in_byte == jsu_pkg::C_LOW_U) ? jsu_pkg::MODE_HEX0
                                                         : jsu_pkg::MODE_PLAIN;
            end
            jsu_pkg::MODE_HEX0: n_mode = jsu_pkg::MODE_HEX1;
            jsu_pkg::MODE_HEX1: n_mode = jsu_pkg::MODE_HEX2;
            jsu_pkg::MODE_HEX2: n_mode = jsu_pkg::MODE_HEX3;
            jsu_pkg::MODE_HEX3: n_mode = jsu_pkg::MODE_PLAIN;
            default: begin
                n_mode = ((i_in_byte == jsu_pkg::C_BSLASH) && !i_string_end)
                       ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_PLAIN;
            end
        endcase
        if (i_string_end) begin
            n_mode = jsu_pkg::MODE_PLAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_PLAIN;
        end else if (w_accept) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (r_mode)
                jsu_pkg::MODE_HEX0: r_hold[0] <= i_in_byte;
                jsu_pkg::MODE_HEX1: r_hold[1] <= i_in_byte;
                jsu_pkg::MODE_HEX2: r_hold[2] <= i_in_byte;
                default: ;
            endcase
        end
    end

    // code point from the leading run of hex digits
    logic [15:0] w_cp;
    logic        w_any_hex;
    always_comb begin
        w_cp      = 16'h0000;
        w_any_hex = jsu_pkg::is_hex(r_hold[0]);
        if (jsu_pkg::is_hex(r_hold[0])) begin
            w_cp = {12'h000, jsu_pkg::hex_nib(r_hold[0])};
            if (jsu_pkg::is_hex(r_hold[1])) begin
                w_cp = {w_cp[11:0], jsu_pkg::hex_nib(r_hold[1])};
                if (jsu_pkg::is_hex(r_hold[2])) begin
                    w_cp = {w_cp[11:0], jsu_pkg::hex_nib(r_hold[2])};
                    if (jsu_pkg::is_hex(i_in_byte)) begin
                        w_cp = {w_cp[11:0], jsu_pkg::hex_nib(i_in_byte)};
                    end
                end
            end
        end
    end

    // replay of a short unicode escape cut by the end of the string
    logic [2:0][7:0] w_rbuf;
    logic [1:0]      w_rn;
    logic [2:0][7:0] w_rres;
    logic [1:0]      w_rcnt;
    always_comb begin
        logic skip;
        skip   = 1'b0;
        w_rres = '0;
        w_rcnt = 2'd0;
        w_rbuf = r_hold;
        case (r_mode)
            jsu_pkg::MODE_HEX0: begin
                w_rbuf[0] = i_in_byte;
                w_rn      = 2'd1;
            end
            jsu_pkg::MODE_HEX1: begin
                w_rbuf[1] = i_in_byte;
                w_rn      = 2'd2;
            end
            default: begin
                w_rbuf[2] = i_in_byte;
                w_rn      = 2'd3;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            if (skip) begin
                skip = 1'b0;
            end else if (i < int'(w_rn)) begin
                if ((w_rbuf[i] == jsu_pkg::C_BSLASH) && (i + 1 < int'(w_rn))) begin
                    skip = 1'b1;
                    if (w_rbuf[i+1] != jsu_pkg::C_LOW_U) begin
                        w_rres[w_rcnt] = jsu_pkg::esc_map(w_rbuf[i+1]);
                        w_rcnt         = w_rcnt + 2'd1;
                    end
                end else begin
                    w_rres[w_rcnt] = w_rbuf[i];
                    w_rcnt         = w_rcnt + 2'd1;
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_group       = '0;
        o_group.fin   = i_string_end;
        case (r_mode)
            jsu_pkg::MODE_ESC: begin
                if (i_in_byte != jsu_pkg::C_LOW_U) begin
                    o_group.bytes[0] = jsu_pkg::esc_map(i_in_byte);
                    o_group.cnt      = 2'd1;
                end
            end
            jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                if (i_string_end) begin
                    o_group.bytes = w_rres;
                    o_group.cnt   = w_rcnt;
                end
            end
            jsu_pkg::MODE_HEX3: begin
                if (w_any_hex) begin
                    if (w_cp < jsu_pkg::C_LIM1) begin
                        o_group.bytes[0] = w_cp[7:0];
                        o_group.cnt      = 2'd1;
                    end else if (w_cp < jsu_pkg::C_LIM2) begin
                        o_group.bytes[0] = jsu_pkg::C_LEAD2 | {3'b000, w_cp[10:6]};
                        o_group.bytes[1] = jsu_pkg::C_CONT
                                         | ({2'b00, w_cp[5:0]} & jsu_pkg::C_CMASK);
                        o_group.cnt      = 2'd2;
                    end else begin
                        o_group.bytes[0] = jsu_pkg::C_LEAD3 | {4'h0, w_cp[15:12]};
                        o_group.bytes[1] = jsu_pkg::C_CONT
                                         | ({2'b00, w_cp[11:6]} & jsu_pkg::C_CMASK);
                        o_group.bytes[2] = jsu_pkg::C_CONT
                                         | ({2'b00, w_cp[5:0]} & jsu_pkg::C_CMASK);
                        o_group.cnt      = 2'd3;
                    end
                end
            end
            default: begin
                if (!((i_in_byte == jsu_pkg::C_BSLASH) && !i_string_end)) begin
                    o_group.bytes[0] = i_in_byte;
                    o_group.cnt      = 2'd1;
                end
            end
        endcase
    end

    assign o_push = w_accept && ((o_group.cnt != 2'd0) || i_string_end);

endmodule

// ----- sv/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue
// Short request queue between the decoder and the output serializer.
// ----------------------------------------------------------------------------
module jsu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_group i_group,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output jsu_pkg::t_group o_head
);

    jsu_pkg::t_group               r_mem [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::Q_AW-1:0]      r_wr;
    logic [jsu_pkg::Q_AW-1:0]      r_rd;
    logic [jsu_pkg::Q_AW:0]        r_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_full  = (r_count == (jsu_pkg::Q_AW+1)'(jsu_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer: sends the bytes of the head request one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  jsu_pkg::t_group i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_run_last,
    output logic            o_string_done
);

    logic [1:0] r_pos;
    logic       w_last;
    logic       w_take;

    assign o_valid = !i_empty;
    assign w_last  = (i_head.cnt == 2'd0) || (r_pos == (i_head.cnt - 2'd1));
    assign w_take  = o_valid && i_ready;
    assign o_pop   = w_take && w_last;

    always_comb begin
        case (r_pos)
            2'd0:    o_out_byte = i_head.bytes[0];
            2'd1:    o_out_byte = i_head.bytes[1];
            2'd2:    o_out_byte = i_head.bytes[2];
            default: o_out_byte = 8'h00;
        endcase
        if (i_head.cnt == 2'd0) begin
            o_out_byte = 8'h00;
        end
    end

    assign o_byte_valid  = (i_head.cnt != 2'd0);
    assign o_run_last    = w_last;
    assign o_string_done = w_last && i_head.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else if (w_take) begin
            r_pos <= w_last ? 2'd0 : (r_pos + 2'd1);
        end
    end

`ifndef SYNTHESIS
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_run_last && o_string_done && (o_out_byte == 8'h00)))
        else $error("end marker malformed");

    a_pos_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (i_head.cnt != 2'd0)) |-> (r_pos < i_head.cnt))
        else $error("position beyond request");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (r_pos == 2'd0))
        else $error("position left over while empty");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_last) |=> (r_pos == $past(r_pos) + 2'd1))
        else $error("position did not advance");
`endif

endmodule

// ----- sv/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape
// JSON string body unescaper producing UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per request (i_in_byte) with i_string_end on
// the last byte of a string, handshake i_valid / o_ready.
// Output channel: one decoded byte per request, handshake o_valid / i_ready,
// with o_byte_valid low on an end-only marker, o_run_last on the final byte
// produced by an input byte and o_string_done on the final byte of a string.
// Each decoded request is registered in the queue and offered from its head.
// Throughput: one input byte per cycle while the queue is not full; the
// output side sends one byte per cycle while i_ready is high, and a unicode
// escape that expands to two or three bytes is absorbed by a four-entry
// queue of decoded requests. Escape prefixes, which give no output, push nothing.
// When the receiver stalls, the queue fills and o_ready drops once it holds
// four requests; the input side resumes as soon as one drains.
// Reset clears the escape state to plain text and empties the queue.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_string_done
);

    logic            w_push;
    jsu_pkg::t_group w_group;
    logic            w_full;
    logic            w_empty;
    logic            w_pop;
    jsu_pkg::t_group w_head;

    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_string_end (i_string_end),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_group      (w_group)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_group),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule

// ----- tb/sv/json_unescape_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_unescape_checker
// Watches both channels of the JSON string unescaper, predicts the decoded
// byte stream from each accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module json_unescape_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_byte_valid,
    input  logic       i_run_last,
    input  logic       i_string_done,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
    } t_decoded;

    t_decoded       expected_bytes[$];
    jsu_pkg::t_mode dec_mode = jsu_pkg::MODE_PLAIN;
    logic [7:0]     hex_chars[3];
    int             fail_total = 0;

    function automatic logic [7:0] unescape_char(input logic [7:0] c);
        case (c)
            jsu_pkg::C_LOW_N: return 8'h0A;
            jsu_pkg::C_LOW_R: return 8'h0D;
            jsu_pkg::C_LOW_T: return 8'h09;
            jsu_pkg::C_LOW_B: return 8'h08;
            jsu_pkg::C_LOW_F: return 8'h0C;
            default: return c;
        endcase
    endfunction

    task automatic predict_request(input logic [7:0] b, input logic fin);
        logic [7:0]  res[3];
        logic [7:0]  c;
        logic [15:0] cp;
        t_decoded    rec;
        int          cnt;
        int          held;
        int          n;
        int          i;
        int          k;
        int          nib;
        int          digits;
        bit          stop;
        cnt = 0;
        case (dec_mode)
            jsu_pkg::MODE_ESC: begin
                if (b == jsu_pkg::C_LOW_U) begin
                    dec_mode = jsu_pkg::MODE_HEX0;
                end else begin
                    res[0] = unescape_char(b);
                    cnt = 1;
                    dec_mode = jsu_pkg::MODE_PLAIN;
                end
            end
            jsu_pkg::MODE_HEX0, jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                held = int'(dec_mode) - int'(jsu_pkg::MODE_HEX0);
                hex_chars[held] = b;
                dec_mode = jsu_pkg::t_mode'(dec_mode + 3'd1);
                // short unicode escape at end: drop the u, decode the rest plainly
                if (fin) begin
                    n = held + 1;
                    i = 0;
                    while (i < n) begin
                        if (hex_chars[i] == jsu_pkg::C_BSLASH && i + 1 < n) begin
                            i++;
                            if (hex_chars[i] != jsu_pkg::C_LOW_U) begin
                                res[cnt] = unescape_char(hex_chars[i]);
                                cnt++;
                            end
                        end else begin
                            res[cnt] = hex_chars[i];
                            cnt++;
                        end
                        i++;
                    end
                end
            end
            jsu_pkg::MODE_HEX3: begin
                cp = '0;
                digits = 0;
                stop = 1'b0;
                for (k = 0; k < 4; k++) begin
                    c = (k < 3) ? hex_chars[k] : b;
                    if (c >= "0" && c <= "9") begin
                        nib = c - "0";
                    end else if (c >= "a" && c <= "f") begin
                        nib = c - "a" + 10;
                    end else if (c >= "A" && c <= "F") begin
                        nib = c - "A" + 10;
                    end else begin
                        nib = -1;
                    end
                    if (!stop) begin
                        if (nib < 0) begin
                            stop = 1'b1;
                        end else begin
                            cp = {cp[11:0], nib[3:0]};
                            digits++;
                        end
                    end
                end
                if (digits > 0) begin
                    if (cp < jsu_pkg::C_LIM1) begin
                        res[0] = cp[7:0];
                        cnt = 1;
                    end else if (cp < jsu_pkg::C_LIM2) begin
                        res[0] = jsu_pkg::C_LEAD2 | {3'b000, cp[10:6]};
                        res[1] = jsu_pkg::C_CONT | {2'b00, cp[5:0]};
                        cnt = 2;
                    end else begin
                        res[0] = jsu_pkg::C_LEAD3 | {4'b0000, cp[15:12]};
                        res[1] = jsu_pkg::C_CONT | {2'b00, cp[11:6]};
                        res[2] = jsu_pkg::C_CONT | {2'b00, cp[5:0]};
                        cnt = 3;
                    end
                end
                dec_mode = jsu_pkg::MODE_PLAIN;
            end
            default: begin
                if (b == jsu_pkg::C_BSLASH && !fin) begin
                    dec_mode = jsu_pkg::MODE_ESC;
                end else begin
                    res[0] = b;
                    cnt = 1;
                    dec_mode = jsu_pkg::MODE_PLAIN;
                end
            end
        endcase
        if (fin) begin
            dec_mode = jsu_pkg::MODE_PLAIN;
        end
        if (cnt == 0) begin
            if (fin) begin
                rec.data = 8'h00;
                rec.byte_valid = 1'b0;
                rec.run_last = 1'b1;
                rec.string_done = 1'b1;
                expected_bytes.push_back(rec);
            end
        end else begin
            for (k = 0; k < cnt; k++) begin
                rec.data = res[k];
                rec.byte_valid = 1'b1;
                rec.run_last = (k == cnt - 1);
                rec.string_done = (k == cnt - 1) && fin;
                expected_bytes.push_back(rec);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            dec_mode = jsu_pkg::MODE_PLAIN;
            expected_bytes.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_request(i_in_byte, i_string_end);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %h byte_valid %0b", i_out_byte,
                        i_byte_valid);
                    fail_total++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want.data) begin
                        $error("out_byte: expected %h, actual %h", want.data, i_out_byte);
                        fail_total++;
                    end
                    if (i_byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, actual %0b", want.byte_valid,
                            i_byte_valid);
                        fail_total++;
                    end
                    if (i_run_last !== want.run_last) begin
                        $error("run_last: expected %0b, actual %0b", want.run_last,
                            i_run_last);
                        fail_total++;
                    end
                    if (i_string_done !== want.string_done) begin
                        $error("string_done: expected %0b, actual %0b", want.string_done,
                            i_string_done);
                        fail_total++;
                    end
                end
            end
        end
        o_pending <= expected_bytes.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives escaped JSON string bodies into the unescaper with random gaps and
// output stalls, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  ITEM_TARGET = 470;
    localparam int  HOLD_CYCLES = 300;
    localparam int  DRAIN_CYCLES = 20;
    localparam time LIMIT_NS = 5_000_000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_end = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       out_run_last;
    logic       out_string_done;
    int         fail_count;
    int         pending;

    int         items_sent = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    bit         rx_hold_req = 1'b0;

    logic [7:0] esc_set[8] = '{jsu_pkg::C_LOW_N, jsu_pkg::C_LOW_R, jsu_pkg::C_LOW_T,
                               jsu_pkg::C_LOW_B, jsu_pkg::C_LOW_F, jsu_pkg::C_BSLASH,
                               8'h22, 8'h2F};

    always #5 i_clk = ~i_clk;

    json_string_unescape dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_in_byte    (in_byte),
        .i_string_end (in_end),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_out_byte   (out_byte),
        .o_byte_valid (out_byte_valid),
        .o_run_last   (out_run_last),
        .o_string_done(out_string_done)
    );

    json_unescape_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_byte    (in_byte),
        .i_string_end (in_end),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_byte   (out_byte),
        .i_byte_valid (out_byte_valid),
        .i_run_last   (out_run_last),
        .i_string_done(out_string_done),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_end <= fin;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // random string of plain bytes, simple escapes and unicode escapes
    task automatic random_string();
        logic [7:0]  s[$];
        logic [7:0]  c;
        logic [15:0] cp;
        logic [3:0]  nib;
        int          ntok;
        int          kind;
        int          good;
        int          k;
        ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        repeat (ntok) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                s.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 60) begin
                s.push_back(jsu_pkg::C_BSLASH);
                if ($urandom_range(0, 3) == 0) begin
                    s.push_back(8'($urandom_range(0, 255)));
                end else begin
                    s.push_back(esc_set[$urandom_range(0, 7)]);
                end
            end else begin
                s.push_back(jsu_pkg::C_BSLASH);
                s.push_back(jsu_pkg::C_LOW_U);
                case ($urandom_range(0, 2))
                    0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                good = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 4;
                for (k = 0; k < 4; k++) begin
                    nib = cp[15 - 4 * k -: 4];
                    if (k < good) begin
                        if (nib < 4'd10) begin
                            c = "0" + nib;
                        end else begin
                            c = ($urandom_range(0, 1) ? "A" : "a") + nib - 4'd10;
                        end
                    end else begin
                        do c = 8'($urandom_range(0, 255));
                        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f")
                            || (c >= "A" && c <= "F"));
                    end
                    s.push_back(c);
                end
            end
        end
        // broken string: cut anywhere, often inside an escape
        if ($urandom_range(0, 7) == 0) begin
            s = s[0 : $urandom_range(0, s.size() - 1)];
        end
        for (k = 0; k < s.size(); k++) begin
            send_byte(s[k], k == s.size() - 1);
        end
    endtask

    // output side stalls
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
                out_ready <= 1'b0;
                stall_left = pick_gap();
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int i;
        int r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings
        send_byte(8'hFF, 1'b1);
        send_byte(jsu_pkg::C_BSLASH, 1'b0);
        send_byte(jsu_pkg::C_LOW_U, 1'b0);
        send_byte("0", 1'b0);
        send_byte("7", 1'b0);
        send_byte("F", 1'b0);
        send_byte("f", 1'b0);
        send_byte(jsu_pkg::C_BSLASH, 1'b0);
        send_byte(jsu_pkg::C_LOW_U, 1'b0);
        send_byte("F", 1'b0);
        send_byte("F", 1'b0);
        send_byte("F", 1'b0);
        send_byte("F", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(jsu_pkg::C_BSLASH, 1'b1);
        send_byte(jsu_pkg::C_BSLASH, 1'b0);
        send_byte(jsu_pkg::C_LOW_U, 1'b0);
        send_byte("4", 1'b0);
        send_byte(jsu_pkg::C_BSLASH, 1'b1);
        send_byte(jsu_pkg::C_BSLASH, 1'b0);
        send_byte(jsu_pkg::C_LOW_U, 1'b0);
        send_byte("G", 1'b0);
        send_byte("1", 1'b0);
        send_byte("2", 1'b0);
        send_byte("3", 1'b1);

        // long output hold-off while input keeps coming
        rx_hold_req = 1'b1;
        tx_calm = 1'b1;
        for (i = 0; i < 16; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == 15);
        end
        repeat (2) random_string();
        tx_calm = 1'b0;
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            tx_calm = (r < 2);
            rx_calm = (r == 1 || r == 2);
            random_string();
            if ($urandom_range(0, 29) == 0) begin
                wait_drained();
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
